@@ hdl/gpr_pkg.sv @@
// Shared package for the GPIO port register block.
// Holds the pin count, register selector codes, reset values and the structs
// passed between the lock sequencer, the register core and the output buffer.
package gpr_pkg;

    localparam int PIN_COUNT = 16;
    localparam int PINS_PER_WORD = 8;
    localparam int NIBBLE_W = 4;
    localparam int LOCK_KEY_BIT = 16;

    localparam logic [31:0] MODE_RESET = 32'h4444_4444;
    localparam logic [15:0] PIN_MASK = 16'((33'd1 << PIN_COUNT) - 33'd1);
    localparam logic [NIBBLE_W-1:0] NIBBLE_ALL = 4'hF;

    localparam logic CMD_READ = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef enum logic [2:0] {
        SEL_MODE_LOW  = 3'd0,
        SEL_MODE_HIGH = 3'd1,
        SEL_INPUT     = 3'd2,
        SEL_OUTPUT    = 3'd3,
        SEL_SET       = 3'd4,
        SEL_RESET     = 3'd5,
        SEL_LOCK      = 3'd6,
        SEL_NONE      = 3'd7
    } reg_sel_t;

    typedef struct packed {
        logic        valid;
        logic        cmd;
        reg_sel_t    sel;
        logic [31:0] wdata;
        logic [15:0] pins;
    } access_t;

    typedef struct packed {
        logic        locked;
        logic [15:0] mask;
    } lock_stat_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] pad_out;
        logic [15:0] pad_drive_enable;
        logic        port_locked;
    } result_t;

endpackage

@@ hdl/gpr_lock.sv @@
// Lock key sequencer of the GPIO port register block.
// Tracks the write-key-1, write-key-0, write-key-1, read, read sequence.
// Depends on gpr_pkg.
module gpr_lock import gpr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  access_t    acc,
    output lock_stat_t stat_cur,
    output lock_stat_t stat_nxt
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_KEY1,
        PH_KEY0,
        PH_KEY1_AGAIN,
        PH_READ1,
        PH_LOCKED
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] mask_reg, mask_next;
    logic        key_set_reg, key_set_next;
    logic        lock_hit;
    logic        key;
    logic        same;
    logic [15:0] wmask;

    assign lock_hit = acc.valid && (acc.sel == SEL_LOCK) && !key_set_reg;
    assign wmask = acc.wdata[15:0] & PIN_MASK;
    assign key = acc.wdata[LOCK_KEY_BIT];
    assign same = (wmask == mask_reg);

    always_comb begin
        phase_next = phase_reg;
        mask_next = mask_reg;
        key_set_next = key_set_reg;
        if (lock_hit) begin
            if (acc.cmd == CMD_WRITE) begin
                mask_next = wmask;
                if (phase_reg == PH_KEY1 && !key && same) begin
                    phase_next = PH_KEY0;
                end else if (phase_reg == PH_KEY0 && key && same) begin
                    phase_next = PH_KEY1_AGAIN;
                end else begin
                    phase_next = key ? PH_KEY1 : PH_IDLE;
                end
            end else begin
                unique case (phase_reg)
                    PH_KEY1_AGAIN: phase_next = PH_READ1;
                    PH_READ1: begin
                        phase_next = PH_LOCKED;
                        key_set_next = 1'b1;
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            mask_reg <= '0;
            key_set_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            mask_reg <= mask_next;
            key_set_reg <= key_set_next;
        end
    end

    assign stat_cur = '{locked: key_set_reg, mask: mask_reg};
    assign stat_nxt = '{locked: key_set_next, mask: mask_next};

    a_lock_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        key_set_reg |=> key_set_reg && $stable(mask_reg))
        else $error("lock released or lock mask changed while locked");

    a_lock_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        !key_set_reg ##1 key_set_reg |-> $past(phase_reg) == PH_READ1
            && $past(acc.valid) && $past(acc.cmd) == CMD_READ)
        else $error("lock set without the full key sequence");

endmodule

@@ hdl/gpr_regs.sv @@
// Register core of the GPIO port register block.
// Holds the mode words and output data and forms the result of each access.
// Depends on gpr_pkg.
module gpr_regs import gpr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  access_t    acc,
    input  lock_stat_t lock_cur,
    input  lock_stat_t lock_nxt,
    output result_t    res
);

    logic [31:0] mode_lo_reg, mode_lo_next;
    logic [31:0] mode_hi_reg, mode_hi_next;
    logic [15:0] out_reg, out_next;
    logic [31:0] wr_lo, wr_hi;
    logic [15:0] drive_en;
    logic [31:0] rd;
    logic        wr;

    assign wr = acc.valid && (acc.cmd == CMD_WRITE);

    always_comb begin
        wr_lo = '0;
        wr_hi = '0;
        for (int i = 0; i < PINS_PER_WORD; i++) begin
            if (i < PIN_COUNT && !(lock_cur.locked && lock_cur.mask[i])) begin
                wr_lo[NIBBLE_W*i +: NIBBLE_W] = NIBBLE_ALL;
            end
            if (i + PINS_PER_WORD < PIN_COUNT
                    && !(lock_cur.locked && lock_cur.mask[i + PINS_PER_WORD])) begin
                wr_hi[NIBBLE_W*i +: NIBBLE_W] = NIBBLE_ALL;
            end
        end
    end

    always_comb begin
        mode_lo_next = mode_lo_reg;
        mode_hi_next = mode_hi_reg;
        out_next = out_reg;
        if (wr) begin
            case (acc.sel)
                SEL_MODE_LOW:  mode_lo_next = (mode_lo_reg & ~wr_lo) | (acc.wdata & wr_lo);
                SEL_MODE_HIGH: mode_hi_next = (mode_hi_reg & ~wr_hi) | (acc.wdata & wr_hi);
                SEL_OUTPUT:    out_next = acc.wdata[15:0] & PIN_MASK;
                SEL_SET:       out_next = ((out_reg & ~acc.wdata[31:16]) | acc.wdata[15:0])
                                          & PIN_MASK;
                SEL_RESET:     out_next = out_reg & ~acc.wdata[15:0];
                default:       out_next = out_reg;
            endcase
        end
    end

    always_comb begin
        drive_en = '0;
        for (int p = 0; p < 16; p++) begin
            if (p < PIN_COUNT) begin
                if (p < PINS_PER_WORD) begin
                    drive_en[p] = |mode_lo_next[NIBBLE_W*p +: 2];
                end else begin
                    drive_en[p] = |mode_hi_next[NIBBLE_W*(p - PINS_PER_WORD) +: 2];
                end
            end
        end
    end

    always_comb begin
        rd = '0;
        if (acc.cmd == CMD_READ) begin
            case (acc.sel)
                SEL_MODE_LOW:  rd = mode_lo_reg;
                SEL_MODE_HIGH: rd = mode_hi_reg;
                SEL_INPUT:     rd = {16'b0, acc.pins & PIN_MASK};
                SEL_OUTPUT:    rd = {16'b0, out_reg};
                SEL_LOCK:      rd = {15'b0, lock_nxt.locked, lock_nxt.mask};
                default:       rd = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_lo_reg <= MODE_RESET;
            mode_hi_reg <= MODE_RESET;
            out_reg <= '0;
        end else begin
            mode_lo_reg <= mode_lo_next;
            mode_hi_reg <= mode_hi_next;
            out_reg <= out_next;
        end
    end

    assign res = '{read_data: rd, pad_out: out_next, pad_drive_enable: drive_en,
                   port_locked: lock_nxt.locked};

endmodule

@@ hdl/gpr_skid.sv @@
// Two-entry result buffer of the GPIO port register block.
// Registers each result and keeps one spare slot so input and output decouple.
// Depends on gpr_pkg.
module gpr_skid import gpr_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg;
    logic    spare_valid_reg;
    result_t main_reg;
    result_t spare_reg;
    logic    push;

    assign in_ready = !spare_valid_reg;
    assign push = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else begin
            if (out_ready || !main_valid_reg) begin
                if (spare_valid_reg) begin
                    main_reg <= spare_reg;
                    spare_valid_reg <= 1'b0;
                end else begin
                    main_valid_reg <= push;
                    main_reg <= in_data;
                end
            end else if (push) begin
                spare_reg <= in_data;
                spare_valid_reg <= 1'b1;
            end
        end
    end

    assign out_valid = main_valid_reg;
    assign out_data = main_reg;

    a_spare_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        spare_valid_reg |-> main_valid_reg)
        else $error("spare slot holds a result while the output slot is empty");

    a_no_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        main_valid_reg && !out_ready && !spare_valid_reg && in_valid
            |=> spare_valid_reg && main_valid_reg)
        else $error("result pushed under back-pressure was dropped");

endmodule

@@ hdl/gpio_port_register_block.sv @@
// GPIO port register block: sixteen pins, mode words, output data with
// bit set/reset, and a keyed configuration lock. Depends on gpr_pkg and
// the gpr_lock, gpr_regs and gpr_skid modules.
//
// Every transaction on the s_ channel is one register access and gives
// exactly one result transaction on the m_ channel. A new access is
// accepted in every cycle while the spare slot is empty: register updates
// and the result are registered at the accepting edge, and a two-entry
// result buffer keeps s_ready high while one result waits for m_ready.
// Each result shows the register state after its access. The lock is
// armed by writing key 1, key 0, key 1 to the lock register with one pin
// mask, then reading it twice; from then on the mode nibbles of masked
// pins hold their values until aresetn is asserted.
module gpio_port_register_block import gpr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [2:0]  s_reg_sel,
    input  logic [31:0] s_write_data,
    input  logic [15:0] s_pin_levels,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic [15:0] m_pad_out,
    output logic [15:0] m_pad_drive_enable,
    output logic        m_port_locked
);

    access_t    acc;
    lock_stat_t lock_cur;
    lock_stat_t lock_nxt;
    result_t    res;
    result_t    res_out;

    assign acc = '{valid: s_valid && s_ready, cmd: s_cmd, sel: reg_sel_t'(s_reg_sel),
                   wdata: s_write_data, pins: s_pin_levels};

    gpr_lock u_lock (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .acc      (acc),
        .stat_cur (lock_cur),
        .stat_nxt (lock_nxt)
    );

    gpr_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .acc      (acc),
        .lock_cur (lock_cur),
        .lock_nxt (lock_nxt),
        .res      (res)
    );

    gpr_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (res_out)
    );

    assign m_read_data = res_out.read_data;
    assign m_pad_out = res_out.pad_out;
    assign m_pad_drive_enable = res_out.pad_drive_enable;
    assign m_port_locked = res_out.port_locked;

endmodule
